>>> rtl/cdn_pkg.sv
`default_nettype none

package cdn_pkg;

    // Field widths
    localparam int YEAR_W  = 16;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int MIN_W   = 13;   // working month, holds abs of 13-bit input
    localparam int DIN_W   = 17;   // working day, holds abs of 17-bit input
    localparam int SUB_W   = 17;   // shared subtractor width

    // Calendar constants
    localparam logic [SUB_W-1:0] GREG_CYCLE     = 17'd400;
    localparam logic [8:0]       GREG_CYCLE_END = 9'd399;
    localparam logic [8:0]       CENTURY_1      = 9'd100;
    localparam logic [8:0]       CENTURY_2      = 9'd200;
    localparam logic [8:0]       CENTURY_3      = 9'd300;
    localparam logic [SUB_W-1:0] MONTHS_PER_YR  = 17'd12;
    localparam logic [MIN_W-1:0] MONTH_LAST     = 13'd12;
    localparam logic [YEAR_W-1:0] YEAR_MAX      = 16'hFFFF;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_REJECT = 2'd1,
        STATUS_SAT    = 2'd2
    } status_t;

    // Shared subtractor result
    typedef struct packed {
        logic [SUB_W-1:0] diff;
        logic             ge;     // a >= b
        logic             gt;     // a >  b
    } sub_res_t;

    // Days in month m (1..12) for a leap or common year
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

>>> rtl/cdn_sub_unit.sv
`default_nettype none

module cdn_sub_unit
    import cdn_pkg::*;
(
    input  wire logic [SUB_W-1:0] a,
    input  wire logic [SUB_W-1:0] b,
    output sub_res_t              res
);

    logic [SUB_W:0] wide_diff;

    // One subtract serves every reduce step of the sequencer and its year and day compares
    always_comb
    begin
        wide_diff = {1'b0, a} - {1'b0, b};
        res.diff  = wide_diff[SUB_W-1:0];
        res.ge    = ~wide_diff[SUB_W];
        res.gt    = ~wide_diff[SUB_W] && (wide_diff[SUB_W-1:0] != '0);
    end

endmodule

`default_nettype wire

>>> rtl/calendar_date_normalizer_unit.sv
// Gregorian date normalizer.
// Input channel s_*: one transaction is a command. s_tuser[0] selects load (0) or
// add day count (1). A load stores |year|, |month|, |day| and normalizes them; an
// add adds a signed day count to the held day, takes the magnitude and normalizes.
// Output channel m_*: exactly one transaction per command carrying the held date
// and a status (ok, rejected zero month/day with the date kept, year saturated).
// After a command is accepted, the sequencer reduces the start year mod 400 (at
// most 163 reductions), then folds months into years and steps the day count
// over whole months; one shared subtractor reduces one month or one 400-year
// block per cycle. A rejected command skips these steps and goes straight to
// the final step.
// s_tready is high only while the sequencer is idle; one command is in flight.
// s_tready returns with m_tvalid. The result sits in an output register, so the
// next command is taken while it waits; if the receiver stalls, the following
// result waits in its final step until the output register frees.
// Reset sets the held date to year 1, month 1, day 1 and clears m_tvalid.
`default_nettype none

module calendar_date_normalizer_unit
    import cdn_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [15:0] year_in, [28:16] month_in, [45:29] day_in, [62:46] day_delta, [63] zero
    input  wire logic [63:0] s_tdata,
    // [0] action
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [15:0] year_out, [19:16] month_out, [24:20] day_out, [26:25] status, [31:27] zero
    output logic [31:0]      m_tdata
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MOD  = 4'b0010,
        ST_NORM = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [YEAR_W-1:0]    cur_year_reg, cur_year_next;
    logic [MONTH_W-1:0]   cur_month_reg, cur_month_next;
    logic [DAY_W-1:0]     cur_day_reg, cur_day_next;
    logic [YEAR_W-1:0]    y_reg, y_next;
    logic [MIN_W-1:0]     m_reg, m_next;
    logic [DIN_W-1:0]     d_reg, d_next;
    logic [YEAR_W-1:0]    res_reg, res_next;
    logic                 sat_reg, sat_next;
    status_t              status_reg, status_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [31:0]          m_tdata_reg, m_tdata_next;

    logic [YEAR_W-1:0]    abs_year;
    logic [MIN_W-1:0]     abs_month;
    logic [DIN_W-1:0]     abs_day;
    logic [17:0]          add_sum;
    logic [17:0]          add_abs;
    logic                 s_fire;
    logic                 leap;
    logic                 fold;
    logic [DAY_W-1:0]     mlen;
    logic [SUB_W-1:0]     sub_a, sub_b;
    sub_res_t             sub_res;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Magnitudes of the command fields
    always_comb
    begin
        abs_year  = s_tdata[15] ? YEAR_W'(~s_tdata[15:0] + 16'd1) : s_tdata[15:0];
        abs_month = s_tdata[28] ? MIN_W'(~s_tdata[28:16] + 13'd1) : s_tdata[28:16];
        abs_day   = s_tdata[45] ? DIN_W'(~s_tdata[45:29] + 17'd1) : s_tdata[45:29];
        add_sum   = {13'd0, cur_day_reg} + {s_tdata[62], s_tdata[62:46]};
        add_abs   = add_sum[17] ? (~add_sum + 18'd1) : add_sum;
    end

    // Leap test from the year residue mod 400 (low bits give mod 4)
    always_comb
    begin
        leap = (res_reg[8:0] == 9'd0) ||
               ((res_reg[1:0] == 2'd0) && (res_reg[8:0] != CENTURY_1) &&
                (res_reg[8:0] != CENTURY_2) && (res_reg[8:0] != CENTURY_3));
        mlen = month_len(m_reg[MONTH_W-1:0], leap);
        fold = (m_reg > MONTH_LAST);
    end

    // Operand select for the shared subtractor
    always_comb
    begin
        if (state_reg == ST_MOD)
        begin
            sub_a = {1'b0, res_reg};
            sub_b = GREG_CYCLE;
        end
        else if (fold)
        begin
            sub_a = {4'd0, m_reg};
            sub_b = MONTHS_PER_YR;
        end
        else
        begin
            sub_a = d_reg;
            sub_b = {12'd0, mlen};
        end
    end

    cdn_sub_unit u_sub (
        .a   (sub_a),
        .b   (sub_b),
        .res (sub_res)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cur_year_next  = cur_year_reg;
        cur_month_next = cur_month_reg;
        cur_day_next   = cur_day_reg;
        y_next         = y_reg;
        m_next         = m_reg;
        d_next         = d_reg;
        res_next       = res_reg;
        sat_next       = sat_reg;
        status_next    = status_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    if (s_tuser[0] == 1'b0)
                    begin
                        y_next = abs_year;
                        m_next = abs_month;
                        d_next = abs_day;
                    end
                    else
                    begin
                        y_next = cur_year_reg;
                        m_next = {9'd0, cur_month_reg};
                        d_next = add_abs[DIN_W-1:0];
                    end
                    res_next = y_next;
                    sat_next = 1'b0;
                    if ((m_next == '0) || (d_next == '0))
                    begin
                        status_next = STATUS_REJECT;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_MOD;
                    end
                end
            end

            // Reduce the year mod 400, one block per cycle
            ST_MOD:
            begin
                if (sub_res.ge)
                    res_next = sub_res.diff[YEAR_W-1:0];
                else
                    state_next = ST_NORM;
            end

            // Fold months into years, then step days into months
            ST_NORM:
            begin
                if (fold)
                begin
                    m_next = sub_res.diff[MIN_W-1:0];
                    if (y_reg == YEAR_MAX)
                    begin
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        y_next   = y_reg + 16'd1;
                        res_next = (res_reg[8:0] == GREG_CYCLE_END) ? '0
                                                                   : res_reg + 16'd1;
                    end
                end
                else if (sub_res.gt)
                begin
                    d_next = sub_res.diff[DIN_W-1:0];
                    m_next = m_reg + 13'd1;
                end
                else
                begin
                    cur_year_next  = y_reg;
                    cur_month_next = m_reg[MONTH_W-1:0];
                    cur_day_next   = d_reg[DAY_W-1:0];
                    status_next    = sat_reg ? STATUS_SAT : STATUS_OK;
                    state_next     = ST_DONE;
                end
            end

            // Hand the result to the output register once it is free
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'd0, status_reg, cur_day_reg, cur_month_reg,
                                     cur_year_reg};
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and held date
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_year_reg  <= 16'd1;
            cur_month_reg <= 4'd1;
            cur_day_reg   <= 5'd1;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_year_reg  <= cur_year_next;
            cur_month_reg <= cur_month_next;
            cur_day_reg   <= cur_day_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Working registers and output payload
    always_ff @(posedge clk)
    begin
        y_reg       <= y_next;
        m_reg       <= m_next;
        d_reg       <= d_next;
        res_reg     <= res_next;
        sat_reg     <= sat_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
    end

`ifndef ASSERT_OFF
    // Held date is always a valid month and day
    a_date_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_month_reg >= 4'd1) && (cur_month_reg <= 4'd12) && (cur_day_reg != 5'd0))
        else $error("held date out of range");

    // Year residue is reduced before normalization runs
    a_res_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NORM) |-> (res_reg < 16'd400))
        else $error("year residue not reduced");

    // A rejected command leaves the held date untouched
    a_reject_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && state_next == ST_DONE) |=>
            ($stable(cur_year_reg) && $stable(cur_month_reg) && $stable(cur_day_reg)
             && status_reg == STATUS_REJECT))
        else $error("rejected command changed the date");

    // Output status code is never the unused encoding
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (m_tdata_reg[26:25] != 2'd3))
        else $error("bad status code on output");
`endif

endmodule

`default_nettype wire

>>> verif/calendar_date_normalizer_unit_tb.sv
`default_nettype none

module calendar_date_normalizer_unit_tb;
    import cdn_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Command kinds carried in s_tuser[0]
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_ADD  = 1'b1;

    // Cycles with no transaction on either side before the run is abandoned
    localparam int STALL_LIMIT = 20000;
    // Max-size steps used to walk the year upward in long normalization runs
    localparam int CLIMB_STEPS = 16;

    typedef struct {
        logic               action;
        logic signed [15:0] year;
        logic signed [12:0] month;
        logic signed [16:0] day;
        logic signed [16:0] delta;
        bit                 drain_first;  // hold off until all results are back
    } date_cmd_t;

    typedef struct {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        status_t            status;
    } date_res_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    date_cmd_t   cmd_q[$];
    date_cmd_t   cmd_on_bus;
    date_res_t   expected_dates[$];
    date_res_t   want;

    // Date held by the predictor
    logic [YEAR_W-1:0]  cal_year;
    logic [MONTH_W-1:0] cal_month;
    logic [DAY_W-1:0]   cal_day;

    int mismatches;
    int sent_count;
    int results_seen;
    int idle_cycles;

    calendar_date_normalizer_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Date arithmetic
    // ---------------------------------------------------------------
    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint month_days(input longint m, input longint y);
        bit leap;
        leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        case (m)
            2:           return leap ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    // Fold months into years and spill days into months until the date is valid
    function automatic status_t date_normalize(input longint y, input longint m,
                                               input longint d);
        bit     sat;
        longint yr;
        longint ymax;
        sat  = 1'b0;
        ymax = longint'(YEAR_MAX);
        if (m == 0 || d == 0)
            return STATUS_REJECT;
        if (y > ymax)
        begin
            y   = ymax;
            sat = 1'b1;
        end
        yr = y;
        while (m > 12 || d > month_days(m, yr))
        begin
            if (m > 12)
            begin
                m -= 12;
                if (yr >= ymax)
                    sat = 1'b1;
                else
                    yr++;
            end
            else
            begin
                d -= month_days(m, yr);
                m++;
            end
        end
        cal_year  = yr[YEAR_W-1:0];
        cal_month = m[MONTH_W-1:0];
        cal_day   = d[DAY_W-1:0];
        return sat ? STATUS_SAT : STATUS_OK;
    endfunction

    // Apply one accepted command and queue the date it should produce
    function automatic void apply_command(input date_cmd_t c);
        date_res_t r;
        longint    y;
        longint    m;
        longint    d;
        longint    sum;
        if (c.action == ACT_LOAD)
        begin
            y = longint'(c.year);
            m = longint'(c.month);
            d = longint'(c.day);
            r.status = date_normalize(magnitude(y), magnitude(m), magnitude(d));
        end
        else
        begin
            sum = longint'(cal_day) + longint'(c.delta);
            r.status = date_normalize(longint'(cal_year), longint'(cal_month),
                                      magnitude(sum));
        end
        r.year  = cal_year;
        r.month = cal_month;
        r.day   = cal_day;
        expected_dates.push_back(r);
    endfunction

    // ---------------------------------------------------------------
    // Stimulus builders; fields a command ignores get random content
    // ---------------------------------------------------------------
    task automatic push_load(input int y, input int m, input int d, input bit drain);
        date_cmd_t c;
        c.action      = ACT_LOAD;
        c.year        = 16'(y);
        c.month       = 13'(m);
        c.day         = 17'(d);
        c.delta       = 17'($urandom);
        c.drain_first = drain;
        cmd_q.push_back(c);
    endtask

    task automatic push_add(input int delta, input bit drain);
        date_cmd_t c;
        c.action      = ACT_ADD;
        c.year        = 16'($urandom);
        c.month       = 13'($urandom);
        c.day         = 17'($urandom);
        c.delta       = 17'(delta);
        c.drain_first = drain;
        cmd_q.push_back(c);
    endtask

    // Mostly small sizes to keep the run short, now and then the full range
    task automatic push_random_cmds(input int count);
        int  i;
        bit  wide;
        bit  drain;
        for (i = 0; i < count; i++)
        begin
            wide  = ($urandom_range(99) < 10);
            drain = ($urandom_range(99) < 5);
            if ($urandom_range(1) == 0)
                push_load($urandom,
                          wide ? int'($urandom) : int'($urandom_range(28)) - 14,
                          wide ? int'($urandom) : int'($urandom_range(80)) - 40,
                          drain);
            else
                push_add(wide ? int'($urandom) : int'($urandom_range(140)) - 70, drain);
        end
    endtask

    task automatic check_field(input string name, input longint exp_v, input longint got_v);
        if (exp_v != got_v)
        begin
            $display("%0t ns: %s mismatch, expected %0d actual %0d",
                     $time, name, exp_v, got_v);
            mismatches++;
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence: directed, random, year climb, random, then drain
    // ---------------------------------------------------------------
    initial
    begin
        int i;
        cal_year    = 16'd1;
        cal_month   = 4'd1;
        cal_day     = 5'd1;
        mismatches  = 0;

        // date at reset, zero sum, negative sum
        push_add(0, 1'b0);
        push_add(-1, 1'b0);
        push_add(-3, 1'b0);
        // zero month, zero day
        push_load(0, 0, 5, 1'b0);
        push_load(2024, 2, 0, 1'b0);
        // February in leap and common years, year zero included
        push_load(0, 2, 29, 1'b0);
        push_load(1900, 2, 29, 1'b0);
        push_load(2000, 2, 29, 1'b0);
        push_load(2023, 2, 29, 1'b0);
        push_load(2023, 2, 28, 1'b0);
        push_add(1, 1'b0);
        push_add(365, 1'b0);
        // year rollover and month folding
        push_load(2023, 12, 31, 1'b0);
        push_add(1, 1'b0);
        push_load(-1, -12, -31, 1'b0);
        push_load(1, 13, 1, 1'b0);
        push_load(0, 24, 31, 1'b0);
        // most negative and most positive fields
        push_load(-32768, -4096, -65536, 1'b1);
        push_load(32767, 4095, 65535, 1'b0);
        push_add(65535, 1'b0);
        push_add(-65536, 1'b0);
        push_add(-65536, 1'b1);

        push_random_cmds(40);

        // walk the year upward with max-size steps
        push_load(32767, 4095, 65535, 1'b1);
        for (i = 0; i < CLIMB_STEPS; i++)
            push_add(($urandom_range(3) == 0) ? -65536 : 65535, 1'b0);

        push_random_cmds(40);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_q.size() != 0 || s_tvalid)
            @(negedge clk);
        while (expected_dates.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);

        if (mismatches == 0)
            $display("PASS calendar_date_normalizer_unit");
        else
            $display("FAIL calendar_date_normalizer_unit");
        $finish;
    end

    // ---------------------------------------------------------------
    // Command driver
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= '0;
            sent_count <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                apply_command(cmd_on_bus);
                sent_count <= sent_count + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                // no random idling while items 40..89 go out
                if (cmd_q.size() != 0
                    && !((sent_count < 40 || sent_count >= 90) && $urandom_range(99) < 8)
                    && !(cmd_q[0].drain_first && expected_dates.size() != 0))
                begin
                    cmd_on_bus = cmd_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {1'b0, cmd_on_bus.delta, cmd_on_bus.day,
                                 cmd_on_bus.month, cmd_on_bus.year};
                    s_tuser  <= cmd_on_bus.action;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Result monitor and receiver back-pressure
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready     <= 1'b0;
            results_seen <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
                if (expected_dates.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none actual %h",
                             $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_dates.pop_front();
                    check_field("year", longint'(want.year), longint'(m_tdata[15:0]));
                    check_field("month", longint'(want.month), longint'(m_tdata[19:16]));
                    check_field("day", longint'(want.day), longint'(m_tdata[24:20]));
                    check_field("status", longint'(want.status),
                                longint'(m_tdata[26:25]));
                end
            end
            // no stalls while results 40..89 come back
            m_tready <= !((results_seen < 40 || results_seen >= 90)
                          && $urandom_range(99) < 8);
        end
    end

    // ---------------------------------------------------------------
    // Watchdog on transaction activity
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL calendar_date_normalizer_unit");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

`default_nettype wire

>>> calendar_date_normalizer_unit.f
rtl/cdn_pkg.sv
rtl/cdn_sub_unit.sv
rtl/calendar_date_normalizer_unit.sv
verif/calendar_date_normalizer_unit_tb.sv
